// ===== rtl/core/csq_pkg.sv =====
// Package for the counting semaphore with FIFO wait queue.
// Holds field widths, counter limits and the operation codes.
// No dependencies.
`default_nettype none

package csq_pkg;

	// Field widths of the request and result.
	localparam int OP_W    = 2;
	localparam int ID_W    = 8;
	localparam int INIT_W  = 8;

	// Semaphore counter: signed, saturating.
	localparam int COUNT_W = 10;
	localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 10'sd511;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN   = -10'sd512;
	localparam logic signed [COUNT_W-1:0] COUNT_RESET = 10'sd1;

	// Operation codes of a request.
	typedef enum logic [OP_W-1:0] {
		OP_WAIT       = 2'd0,
		OP_SIGNAL     = 2'd1,
		OP_SIGNAL_ALL = 2'd2,
		OP_NOP        = 2'd3
	} op_t;

endpackage : csq_pkg

`default_nettype wire

// ===== rtl/core/csq_id_mem.sv =====
// Blocked-id store of the semaphore: one write port, one synchronous read port.
// The read returns the written data when both ports hit the same entry.
// Depends on csq_pkg.
`default_nettype none

module csq_id_mem #(
	parameter int DEPTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  wire logic [csq_pkg::ID_W-1:0]            wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic      [csq_pkg::ID_W-1:0]            rd_data
);
	import csq_pkg::*;

	logic [ID_W-1:0] mem [DEPTH];
	logic [ID_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with write-first forwarding on an address collision.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule : csq_id_mem

`default_nettype wire

// ===== rtl/core/counting_semaphore_wait_queue.sv =====
// Top level of the counting semaphore with FIFO wait queue.
// Instantiates csq_id_mem; depends on csq_pkg.
`default_nettype none

// A wait, signal or signal-all request is taken and its result is in the
// output register on the next cycle. A new request is taken only while that
// register is empty or its result is taken in the same cycle, so requests
// follow back to back while the result side does not stall.
// A signal-all that releases N queued ids gives N results, one per cycle
// while the result side does not stall, and takes no new request until the
// last is in the output register; that drain rate is set by the single read
// port of the id memory, which always holds the oldest queued id ready.
// The counter saturates at -512 and 511 and is reloaded from cfg_wr_data on
// every configuration write; the queue is kept across such writes.
// No clearing pass is needed after reset.
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration.
	input  wire logic                          cfg_wr_en,
	input  wire logic [csq_pkg::INIT_W-1:0]    cfg_wr_data,
	// Request channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [csq_pkg::OP_W-1:0]      operation,
	input  wire logic [csq_pkg::ID_W-1:0]      process_id,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               proceed,
	output logic                               woken_valid,
	output logic [csq_pkg::ID_W-1:0]           woken_id,
	output logic                               queue_full_error,
	output logic                               last
);
	import csq_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
	localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                     state_q, state_d;
	logic signed [COUNT_W-1:0]  count_q, count_d, count_dec, count_inc;
	logic [PTR_W-1:0]           head_q, head_d, tail_q, tail_d;
	logic [FILL_W-1:0]          fill_q, fill_d;

	logic                       out_valid_q, out_free, out_load;
	logic                       proceed_q, woken_valid_q, queue_full_error_q, last_q;
	logic [ID_W-1:0]            woken_id_q;
	logic                       res_proceed, res_woken_valid, res_error, res_last;
	logic [ID_W-1:0]            res_woken_id;

	logic                       in_take;
	op_t                        op;
	logic                       mem_wr_en;
	logic [ID_W-1:0]            head_id;

	// Next slot in the circular queue.
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// The output register can take a new result this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_take  = in_valid && !in_stall;
	assign op       = op_t'(operation);

	// Saturating counter steps.
	assign count_dec = (count_q == COUNT_MIN) ? COUNT_MIN : count_q - COUNT_W'(1);
	assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_W'(1);

	// Request decode, queue update and result formation.
	always_comb begin
		state_d         = state_q;
		count_d         = count_q;
		head_d          = head_q;
		tail_d          = tail_q;
		fill_d          = fill_q;
		mem_wr_en       = 1'b0;
		out_load        = 1'b0;
		res_proceed     = 1'b0;
		res_woken_valid = 1'b0;
		res_woken_id    = '0;
		res_error       = 1'b0;
		res_last        = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					case (op)
						OP_WAIT: begin
							out_load = 1'b1;
							count_d  = count_dec;
							if (!count_dec[COUNT_W-1]) begin
								res_proceed = 1'b1;
							end else if (fill_q == FILL_FULL) begin
								res_error = 1'b1;
							end else begin
								mem_wr_en = 1'b1;
								tail_d    = next_slot(tail_q);
								fill_d    = fill_q + FILL_W'(1);
							end
						end
						OP_SIGNAL: begin
							out_load = 1'b1;
							count_d  = count_inc;
							if (!count_inc[COUNT_W-1] && (count_inc != '0)) begin
								res_proceed = 1'b1;
							end else if (fill_q != '0) begin
								res_woken_valid = 1'b1;
								res_woken_id    = head_id;
								head_d          = next_slot(head_q);
								fill_d          = fill_q - FILL_W'(1);
							end
						end
						OP_SIGNAL_ALL: begin
							out_load = 1'b1;
							count_d  = count_inc;
							if (!count_inc[COUNT_W-1] && (count_inc != '0)) begin
								res_proceed = 1'b1;
							end else if (fill_q != '0) begin
								res_woken_valid = 1'b1;
								res_woken_id    = head_id;
								fill_d          = fill_q - FILL_W'(1);
								if (fill_q == FILL_ONE) begin
									head_d = '0;
									tail_d = '0;
								end else begin
									res_last = 1'b0;
									head_d   = next_slot(head_q);
									state_d  = ST_DRAIN;
								end
							end
						end
						default: begin
							// Unused code: accepted and dropped without a result.
						end
					endcase
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					out_load        = 1'b1;
					res_woken_valid = 1'b1;
					res_woken_id    = head_id;
					fill_d          = fill_q - FILL_W'(1);
					if (fill_q == FILL_ONE) begin
						head_d  = '0;
						tail_d  = '0;
						state_d = ST_IDLE;
					end else begin
						res_last = 1'b0;
						head_d   = next_slot(head_q);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Id memory: always reads the entry that will be the head next cycle.
	csq_id_mem #(
		.DEPTH (QUEUE_DEPTH)
	) u_id_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (tail_q),
		.wr_data (process_id),
		.rd_addr (head_d),
		.rd_data (head_id)
	);

	// Control state and counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= COUNT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			if (cfg_wr_en) begin
				count_q <= COUNT_W'(cfg_wr_data);
			end else begin
				count_q <= count_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			proceed_q          <= res_proceed;
			woken_valid_q      <= res_woken_valid;
			woken_id_q         <= res_woken_id;
			queue_full_error_q <= res_error;
			last_q             <= res_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign proceed          = proceed_q;
	assign woken_valid      = woken_valid_q;
	assign woken_id         = woken_id_q;
	assign queue_full_error = queue_full_error_q;
	assign last             = last_q;

endmodule : counting_semaphore_wait_queue

`default_nettype wire
